### hw/rtl/rkht_pkg.sv
// shared constants, types and command/status structs of the refcounted key table
package rkht_pkg;

    localparam int BUCKETS    = 256;
    localparam int WAYS       = 4;
    localparam int COUNT_BITS = 16;

    localparam int KEY_W      = 64;
    localparam int SHIFT_W    = 4;
    localparam int STATUS_W   = 3;
    localparam int CNT_OUT_W  = 16;
    localparam int BKT_W      = $clog2(BUCKETS);

    localparam logic [SHIFT_W-1:0]    SHIFT_RESET = SHIFT_W'(6);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX   = '1;

    localparam logic CMD_ACQUIRE = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_ZERO_KEY  = 3'd3,
        ST_SATURATED = 3'd4
    } t_status;

    typedef struct packed {
        logic                  valid;
        logic [KEY_W-1:0]      key;
        logic [COUNT_BITS-1:0] count;
    } t_entry;

    typedef t_entry [WAYS-1:0] t_row;

    // controller -> datapath
    typedef struct packed {
        logic clear;   // write an empty row at the sweep address
        logic load;    // take the request word and read its bucket
        logic commit;  // write the bucket back and load the result
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clear_last;  // sweep is at the last bucket
        logic out_stall;   // result register full and not being drained
    } t_dp_stat;

endpackage

### hw/rtl/rkht_if.sv
// request and response channel interfaces

interface rkht_req_if;
    logic                      valid;
    logic                      ready;
    logic                      command;
    logic [rkht_pkg::KEY_W-1:0] key;

    modport source (output valid, output command, output key, input ready);
    modport sink   (input valid, input command, input key, output ready);
endinterface

interface rkht_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [rkht_pkg::STATUS_W-1:0]  status;
    logic [rkht_pkg::CNT_OUT_W-1:0] count_after;
    logic                          entry_created;
    logic                          entry_freed;

    modport source (output valid, output status, output count_after,
                    output entry_created, output entry_freed, input ready);
    modport sink   (input valid, input status, input count_after,
                    input entry_created, input entry_freed, output ready);
endinterface

### hw/rtl/rkht_ctrl.sv
// controller state machine: clear sweep, request accept, bucket write-back
module rkht_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  rkht_pkg::t_dp_stat i_stat,
    output rkht_pkg::t_dp_cmd  o_cmd
);
    import rkht_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EVAL  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_req_ready  = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                // hold the bucket until the result register can take the word
                if (!i_stat.out_stall) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

### hw/rtl/rkht_dpath.sv
// datapath: bucket memory, way match, count update and result register
module rkht_dpath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rkht_pkg::t_dp_cmd              i_cmd,
    output rkht_pkg::t_dp_stat             o_stat,
    input  logic                           i_cfg_we,
    input  logic [rkht_pkg::SHIFT_W-1:0]   i_cfg_data,
    input  logic                           i_command,
    input  logic [rkht_pkg::KEY_W-1:0]     i_key,
    input  logic                           i_rsp_ready,
    output logic                           o_rsp_valid,
    output logic [rkht_pkg::STATUS_W-1:0]  o_status,
    output logic [rkht_pkg::CNT_OUT_W-1:0] o_count_after,
    output logic                           o_entry_created,
    output logic                           o_entry_freed
);
    import rkht_pkg::*;

    t_row mem [BUCKETS];

    logic [SHIFT_W-1:0]    r_align_shift;
    logic [BKT_W-1:0]      r_clr_addr;
    logic                  r_command;
    logic [KEY_W-1:0]      r_key;
    logic [BKT_W-1:0]      r_bkt;
    t_row                  r_rdata;
    logic                  r_out_valid;
    t_status               r_status;
    logic [CNT_OUT_W-1:0]  r_count;
    logic                  r_created;
    logic                  r_freed;

    logic [KEY_W-1:0]      shifted;
    logic [BKT_W-1:0]      rd_bkt;
    logic [WAYS-1:0]       hit_vec;
    logic [WAYS-1:0]       free_vec;
    logic [WAYS-1:0]       hit_oh;
    logic [WAYS-1:0]       free_oh;
    logic [WAYS-1:0]       upd_oh;
    logic                  hit_any;
    logic                  free_any;
    logic [COUNT_BITS-1:0] sel_count;
    t_entry                new_entry;
    t_row                  n_row;
    t_status               n_status;
    logic [COUNT_BITS-1:0] n_count;
    logic [31:0]           count_wide;
    logic                  n_created;
    logic                  n_freed;

    // bucket select
    assign shifted = i_key >> r_align_shift;
    assign rd_bkt  = shifted[BKT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_align_shift <= SHIFT_RESET;
        end else if (i_cfg_we) begin
            r_align_shift <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_addr <= r_clr_addr + BKT_W'(1);
        end
    end

    assign o_stat.clear_last = (r_clr_addr == BKT_W'(BUCKETS - 1));
    assign o_stat.out_stall  = r_out_valid && !i_rsp_ready;

    // bucket memory: one row of all ways per bucket
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            mem[r_clr_addr] <= '0;
        end else if (i_cmd.commit) begin
            mem[r_bkt] <= n_row;
        end
        if (i_cmd.load) begin
            r_rdata <= mem[rd_bkt];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_command <= i_command;
            r_key     <= i_key;
            r_bkt     <= rd_bkt;
        end
    end

    // way match
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            hit_vec[w]  = r_rdata[w].valid && (r_rdata[w].key == r_key);
            free_vec[w] = !r_rdata[w].valid;
        end
    end

    // lowest matching way and lowest free way
    assign hit_oh   = hit_vec & (~hit_vec + WAYS'(1));
    assign free_oh  = free_vec & (~free_vec + WAYS'(1));
    assign hit_any  = |hit_vec;
    assign free_any = |free_vec;

    always_comb begin
        sel_count = '0;
        for (int w = 0; w < WAYS; w++) begin
            sel_count = sel_count | (hit_oh[w] ? r_rdata[w].count : '0);
        end
    end

    // update decision
    always_comb begin
        n_status        = ST_OK;
        n_count         = '0;
        n_created       = 1'b0;
        n_freed         = 1'b0;
        upd_oh          = '0;
        new_entry.valid = 1'b1;
        new_entry.key   = r_key;
        new_entry.count = '0;
        priority if (r_key == '0) begin
            n_status = ST_ZERO_KEY;
        end else if (r_command == CMD_ACQUIRE) begin
            priority if (hit_any) begin
                if (sel_count == COUNT_MAX) begin
                    n_status = ST_SATURATED;
                    n_count  = sel_count;
                end else begin
                    n_count = sel_count + COUNT_BITS'(1);
                    upd_oh  = hit_oh;
                end
                new_entry.count = n_count;
            end else if (free_any) begin
                n_count         = COUNT_BITS'(1);
                new_entry.count = COUNT_BITS'(1);
                upd_oh          = free_oh;
                n_created       = 1'b1;
            end else begin
                n_status = ST_FULL;
            end
        end else begin
            if (!hit_any) begin
                n_status = ST_NOT_FOUND;
            end else begin
                n_count         = (sel_count == '0) ? '0 : sel_count - COUNT_BITS'(1);
                new_entry.count = n_count;
                upd_oh          = hit_oh;
                if (n_count == '0) begin
                    new_entry.valid = 1'b0;
                    n_freed         = 1'b1;
                end
            end
        end
    end

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            n_row[w] = upd_oh[w] ? new_entry : r_rdata[w];
        end
    end

    assign count_wide = 32'(n_count);

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status  <= n_status;
            r_count   <= count_wide[CNT_OUT_W-1:0];
            r_created <= n_created;
            r_freed   <= n_freed;
        end
    end

    assign o_rsp_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_count_after   = r_count;
    assign o_entry_created = r_created;
    assign o_entry_freed   = r_freed;

endmodule

### hw/rtl/refcounted_key_hash_table.sv
// top level of the reference-counted key table
//
// usage:
//  - request channel i_req carries one word per acquire (command 0) or
//    release (command 1) of a 64-bit key; zero keys are rejected
//  - response channel o_rsp returns exactly one word per request, in order:
//    status, count after the request, entry created and entry freed flags
//  - i_cfg_we / i_cfg_data write align_shift (key bits dropped before the
//    bucket select); write it only while no request is in flight
//  - each request first reads its bucket row from the single-port table
//    memory, then matches the ways, updates the count and writes the row
//    back; the next request is taken in the cycle after that, so a new
//    request is not taken before the last one is written back
//  - the result sits in an output register; a stalled receiver does not
//    block the next request's read, only its write-back waits until the
//    register drains
//  - after reset the table memory is swept empty, one bucket a cycle, through
//    all BUCKETS (256) buckets, with i_req.ready low; align_shift resets to 6
module refcounted_key_hash_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rkht_pkg::SHIFT_W-1:0]  i_cfg_data,
    rkht_req_if.sink                      i_req,
    rkht_rsp_if.source                    o_rsp
);
    import rkht_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequencing: clear sweep, accept, write-back
    rkht_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // table memory, match/update logic and result register
    rkht_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_command       (i_req.command),
        .i_key           (i_req.key),
        .i_rsp_ready     (o_rsp.ready),
        .o_rsp_valid     (o_rsp.valid),
        .o_status        (o_rsp.status),
        .o_count_after   (o_rsp.count_after),
        .o_entry_created (o_rsp.entry_created),
        .o_entry_freed   (o_rsp.entry_freed)
    );

`ifndef SYNTH
    // no request is taken while the sweep still owns the memory
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clear |-> !i_req.ready)
        else $error("request accepted during clear sweep");

    // write-back never overwrites an undelivered result
    a_commit_not_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> !stat.out_stall)
        else $error("commit while result register stalled");

    // no request is accepted in the cycle right after an accepted one
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("back-to-back accept with bucket read in flight");

    // a response only appears after a write-back
    a_rsp_after_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> $past(cmd.commit))
        else $error("response without write-back");
`endif

endmodule

### bench/refcounted_key_hash_table_tb.sv
// self-checking testbench of the refcounted key table: directed and random traffic
module refcounted_key_hash_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rkht_pkg::*;

    localparam int SLOTS           = BUCKETS * WAYS;
    localparam int IDLE_PCT        = 14;
    localparam int POOL_KEYS       = 15;
    localparam int ITEMS_PER_SHIFT = 210;

    typedef struct packed {
        logic             command;
        logic [KEY_W-1:0] key;
    } request_t;

    typedef struct packed {
        t_status              status;
        logic [CNT_OUT_W-1:0] count;
        logic                 created;
        logic                 freed;
    } outcome_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [SHIFT_W-1:0]   cfg_data;

    rkht_req_if req_ch ();
    rkht_rsp_if rsp_ch ();

    refcounted_key_hash_table i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    // mirror of the table contents and the shift register
    logic [KEY_W-1:0]      slot_key   [SLOTS];
    logic [COUNT_BITS-1:0] slot_count [SLOTS];
    bit                    slot_used  [SLOTS];
    logic [SHIFT_W-1:0]    key_shift;

    request_t request_q [$];   // words waiting to be driven
    outcome_t outcome_q [$];   // outcomes of accepted words, oldest first

    bit steady;                // no random idling on either side
    int mismatches;
    int results_checked;
    int shift_settings;
    int status_seen [8];

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // apply one request to the mirror and return what the block must answer
    function automatic outcome_t refcount_update(input logic cmd, input logic [KEY_W-1:0] key);
        outcome_t res;
        int       base;
        int       hit;
        int       spare;
        res        = '0;
        res.status = ST_OK;
        if (key == '0) begin
            res.status = ST_ZERO_KEY;
            return res;
        end
        base  = int'((key >> key_shift) & 64'(BUCKETS - 1)) * WAYS;
        hit   = -1;
        spare = -1;
        // first matching way, lowest free way
        for (int w = 0; w < WAYS; w++) begin
            if (slot_used[base + w]) begin
                if (hit < 0 && slot_key[base + w] == key) hit = base + w;
            end else if (spare < 0) begin
                spare = base + w;
            end
        end
        if (cmd == CMD_ACQUIRE) begin
            if (hit >= 0) begin
                if (slot_count[hit] == COUNT_MAX) res.status = ST_SATURATED;
                else slot_count[hit] = slot_count[hit] + 1'b1;
                res.count = CNT_OUT_W'(slot_count[hit]);
            end else if (spare >= 0) begin
                slot_used[spare]  = 1'b1;
                slot_key[spare]   = key;
                slot_count[spare] = COUNT_BITS'(1);
                res.count         = CNT_OUT_W'(1);
                res.created       = 1'b1;
            end else begin
                res.status = ST_FULL;
            end
        end else begin
            if (hit < 0) begin
                res.status = ST_NOT_FOUND;
            end else begin
                if (slot_count[hit] != '0) slot_count[hit] = slot_count[hit] - 1'b1;
                res.count = CNT_OUT_W'(slot_count[hit]);
                if (slot_count[hit] == '0) begin
                    slot_used[hit] = 1'b0;
                    res.freed      = 1'b1;
                end
            end
        end
        return res;
    endfunction

    function automatic void report(input string what, input logic [63:0] want_v,
                                   input logic [63:0] got_v);
        mismatches++;
        $display("%0t ns: %s expected %0h actual %0h", $time, what, want_v, got_v);
    endfunction

    task automatic queue_request(input logic cmd, input logic [KEY_W-1:0] key);
        request_q.push_back('{command: cmd, key: key});
    endtask

    // wait until every word is accepted and every outcome has come back
    task automatic wait_idle();
        while (request_q.size() != 0 || req_ch.valid || outcome_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_shift(input logic [SHIFT_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_data  <= value;
        key_shift  = value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        shift_settings++;
    endtask

    // request driver: holds a word until it is taken, idles at random between words
    always @(posedge clk) begin
        request_t next_word;
        if (!rst_n) begin
            req_ch.valid   <= 1'b0;
            req_ch.command <= CMD_ACQUIRE;
            req_ch.key     <= '0;
        end else begin
            // the word leaving now is scored against the mirror at this very edge
            if (req_ch.valid && req_ch.ready)
                outcome_q.push_back(refcount_update(req_ch.command, req_ch.key));
            if (!req_ch.valid || req_ch.ready) begin
                if (request_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                    next_word       = request_q.pop_front();
                    req_ch.valid   <= 1'b1;
                    req_ch.command <= next_word.command;
                    req_ch.key     <= next_word.key;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // response monitor: random back-pressure, field by field check against the oldest outcome
    always @(posedge clk) begin
        outcome_t want;
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                results_checked++;
                status_seen[rsp_ch.status]++;
                if (outcome_q.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: response word expected none actual status %0d",
                             $time, rsp_ch.status);
                end else begin
                    want = outcome_q.pop_front();
                    if (rsp_ch.status !== want.status)
                        report("status", 64'(want.status), 64'(rsp_ch.status));
                    if (rsp_ch.count_after !== want.count)
                        report("count_after", 64'(want.count), 64'(rsp_ch.count_after));
                    if (rsp_ch.entry_created !== want.created)
                        report("entry_created", 64'(want.created), 64'(rsp_ch.entry_created));
                    if (rsp_ch.entry_freed !== want.freed)
                        report("entry_freed", 64'(want.freed), 64'(rsp_ch.entry_freed));
                end
            end
            rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // stimulus sequence
    initial begin
        logic [SHIFT_W-1:0] shift_plan [5];
        logic [KEY_W-1:0]   hot_keys [POOL_KEYS];
        logic [KEY_W-1:0]   rnd;
        logic [KEY_W-1:0]   key;
        int                 hot_buckets [3];
        int                 pick;

        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_data       <= '0;
        foreach (slot_used[i]) slot_used[i] = 1'b0;
        key_shift      = SHIFT_RESET;
        shift_settings = 1;
        steady         = 1'b0;
        shift_plan     = '{4'd15, 4'd12, 4'd0, 4'd3, 4'd9};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed part at the reset shift of 6: bucket is key[13:6]
        queue_request(CMD_ACQUIRE, '0);              // zero key on both commands
        queue_request(CMD_RELEASE, '0);
        queue_request(CMD_RELEASE, 64'h40);          // release of a key never seen
        queue_request(CMD_ACQUIRE, 64'h1);           // new entry
        queue_request(CMD_ACQUIRE, 64'h1);           // second reference
        queue_request(CMD_ACQUIRE, '1);              // all ones, last bucket
        for (int i = 1; i <= 5; i++)                 // bucket 5 fills, fifth key finds it full
            queue_request(CMD_ACQUIRE, (64'(i) << 40) | 64'h140);
        queue_request(CMD_RELEASE, (64'd2 << 40) | 64'h140);  // frees way 1
        queue_request(CMD_ACQUIRE, (64'd5 << 40) | 64'h140);  // reuses the freed way
        queue_request(CMD_ACQUIRE, (64'd2 << 40) | 64'h140);  // full again
        queue_request(CMD_RELEASE, 64'h1);
        queue_request(CMD_RELEASE, 64'h1);           // count reaches zero
        queue_request(CMD_RELEASE, 64'h1);           // already gone
        queue_request(CMD_RELEASE, '1);
        queue_request(CMD_ACQUIRE, 64'h8000_0000_0000_0000);
        wait_idle();

        // random part: per shift a pool of keys crowded into three buckets,
        // mixed with fully random keys and a few zero keys;
        // the first shift setting runs with no idling on either side
        foreach (shift_plan[s]) begin
            set_shift(shift_plan[s]);
            steady = (s == 0);
            foreach (hot_buckets[b]) hot_buckets[b] = $urandom_range(BUCKETS - 1);
            for (int k = 0; k < POOL_KEYS; k++) begin
                rnd         = {$urandom, $urandom};
                hot_keys[k] = (rnd & ~(64'(BUCKETS - 1) << key_shift))
                            | (64'(hot_buckets[k % 3]) << key_shift);
            end
            for (int n = 0; n < ITEMS_PER_SHIFT; n++) begin
                pick = $urandom_range(99);
                if (pick < 3)       key = '0;
                else if (pick < 15) key = {$urandom, $urandom};
                else                key = hot_keys[$urandom_range(POOL_KEYS - 1)];
                queue_request($urandom_range(1) ? CMD_RELEASE : CMD_ACQUIRE, key);
            end
            wait_idle();
            steady = 1'b0;
        end

        // let any stray word surface before judging
        repeat (8) @(posedge clk);
        if (outcome_q.size() != 0) begin
            mismatches++;
            $display("%0t ns: %0d outcomes never answered", $time, outcome_q.size());
        end

        $display("covered %0d responses over %0d shift settings, %0d mismatches",
                 results_checked, shift_settings, mismatches);
        $display("statuses: ok %0d, bucket full %0d, not found %0d, zero key %0d, saturated %0d",
                 status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_NOT_FOUND],
                 status_seen[ST_ZERO_KEY], status_seen[ST_SATURATED]);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("timeout with %0d words queued, %0d outcomes waiting",
                 request_q.size(), outcome_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/rkht_pkg.sv
hw/rtl/rkht_if.sv
hw/rtl/rkht_ctrl.sv
hw/rtl/rkht_dpath.sv
hw/rtl/refcounted_key_hash_table.sv
bench/refcounted_key_hash_table_tb.sv
